// ===== hw/rtl/ptt_pkg.sv =====
package ptt_pkg;

	localparam int NUM_SLOTS_DEF  = 8;
	localparam int NUM_TIMERS_DEF = 8;

	localparam logic [2:0] ACT_TICK    = 3'd0;
	localparam logic [2:0] ACT_CREATE  = 3'd1;
	localparam logic [2:0] ACT_START   = 3'd2;
	localparam logic [2:0] ACT_RESTART = 3'd3;
	localparam logic [2:0] ACT_STOP    = 3'd4;
	localparam logic [2:0] ACT_DESTROY = 3'd5;
	localparam logic [2:0] ACT_READ    = 3'd6;
	localparam logic [2:0] ACT_WAIT    = 3'd7;

	typedef struct packed {
		logic [2:0]  action;
		logic [2:0]  task_slot;
		logic [2:0]  tmr_sel;
		logic [31:0] period_ticks;
		logic [1:0]  mode_flags;
		logic        wait_on_timer;
	} in_item_t;

	typedef struct packed {
		logic        status;
		logic [7:0]  ready_mask;
		logic [7:0]  expired_mask;
		logic [2:0]  last_wake_index;
		logic        woke_by_timer;
	} out_item_t;

	// Command classified by the front end
	typedef struct packed {
		in_item_t item;
		logic     slot_ok;
		logic     timer_ok;
	} cmd_t;

endpackage

// ===== hw/rtl/per_task_timer_bank_core.sv =====
// Per-task timer bank.
// Input channel (in_valid/in_ready/in_item) takes one action per transfer;
// every action yields exactly one result transfer on out_valid/out_ready.
// Configuration channel (cfg_valid/cfg_ready/cfg_data) sets os_started and
// is always ready; the user must write it only while the block is idle, as
// the block does not enforce this. A front queue of two entries classifies
// slot and timer ranges so input transfers are taken while the back end works or
// waits on the receiver. Non-tick actions pass through the back-end states
// read, execute and output. A tick with os_started set walks every memory
// entry one per cycle in the scan state (the walk spans the power-of-two
// address space); with os_started clear it only yields a result.
// One item is worked on at a time.
// Reset clears the tick count, the marks of all timers and per-slot state;
// deadline and reload memories are not cleared, they are written by create first.
// A stalled receiver holds the result; the queue fills, then in_ready drops.
module per_task_timer_bank_core #(
	parameter int NUM_SLOTS  = ptt_pkg::NUM_SLOTS_DEF,
	parameter int NUM_TIMERS = ptt_pkg::NUM_TIMERS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  ptt_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output ptt_pkg::out_item_t out_item,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_data
);
	ptt_pkg::cmd_t cmd;
	logic cmd_valid, cmd_ready, os_q;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) os_q <= 1'b0;
		else if (cfg_valid) os_q <= cfg_data;
	end

	ptt_front #(.NUM_SLOTS(NUM_SLOTS), .NUM_TIMERS(NUM_TIMERS)) u_front (
		.clk(clk), .arst_n(arst_n), .in_item(in_item), .in_valid(in_valid),
		.in_ready(in_ready), .cmd(cmd), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready));

	ptt_back #(.NUM_SLOTS(NUM_SLOTS), .NUM_TIMERS(NUM_TIMERS)) u_back (
		.clk(clk), .arst_n(arst_n), .os_started(os_q), .cmd(cmd), .cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready), .out_item(out_item), .out_valid(out_valid),
		.out_ready(out_ready));
endmodule

// ===== hw/rtl/ptt_ram.sv =====
module ptt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== hw/rtl/ptt_front.sv =====
module ptt_front #(
	parameter int NUM_SLOTS  = ptt_pkg::NUM_SLOTS_DEF,
	parameter int NUM_TIMERS = ptt_pkg::NUM_TIMERS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ptt_pkg::in_item_t in_item,
	input  logic             in_valid,
	output logic             in_ready,
	output ptt_pkg::cmd_t    cmd,
	output logic             cmd_valid,
	input  logic             cmd_ready
);
	// Two-entry queue with range classification on entry
	ptt_pkg::cmd_t q_q [2];
	logic          wp_q, rp_q;
	logic [1:0]    cnt_q;
	ptt_pkg::cmd_t c;

	always_comb begin
		c.item     = in_item;
		c.slot_ok  = {29'd0, in_item.task_slot} < NUM_SLOTS;
		c.timer_ok = {29'd0, in_item.tmr_sel} < NUM_TIMERS;
	end

	assign in_ready  = cnt_q != 2'd2;
	assign cmd_valid = cnt_q != 2'd0;
	assign cmd       = q_q[rp_q];

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) q_q[wp_q] <= c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (in_valid && in_ready) wp_q <= ~wp_q;
			if (cmd_valid && cmd_ready) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, in_valid && in_ready} - {1'b0, cmd_valid && cmd_ready};
		end
	end
endmodule

// ===== hw/rtl/ptt_back.sv =====
module ptt_back #(
	parameter int NUM_SLOTS  = ptt_pkg::NUM_SLOTS_DEF,
	parameter int NUM_TIMERS = ptt_pkg::NUM_TIMERS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               os_started,
	input  ptt_pkg::cmd_t      cmd,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	output ptt_pkg::out_item_t out_item,
	output logic               out_valid,
	input  logic               out_ready
);
	localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int TW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int AW = SW + TW;
	localparam int DEPTH = 1 << AW;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_RD   = 5'b00010,
		ST_EXEC = 5'b00100,
		ST_SCAN = 5'b01000,
		ST_OUT  = 5'b10000
	} st_t;

	st_t st_q;
	ptt_pkg::cmd_t c_q;
	logic [31:0] tick_q;
	logic [DEPTH-1:0] mk_vld_q;   // mark entry written since reset
	logic [7:0] exp_q [NUM_SLOTS];
	logic [2:0] widx_q [NUM_SLOTS];
	logic wby_q [NUM_SLOTS];
	logic wait_q [NUM_SLOTS];
	logic [AW:0] scan_q;
	logic [7:0] ready_q;
	ptt_pkg::out_item_t res_q;

	// Deadline, reload and mark memories
	logic dl_we, rl_we, mk_we;
	logic [AW-1:0] waddr, raddr, caddr, saddr;
	logic [31:0] dl_wd, dl_rd, rl_rd;
	logic [2:0] mk_wd, mk_rd;

	logic [SW-1:0] cs;
	logic [TW-1:0] ct;
	logic [SW-1:0] ss;
	logic [TW-1:0] stt;
	logic [2:0] cm, sm;
	logic make, hit, live, ss_in_mask;

	ptt_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_dl (
		.clk(clk), .we(dl_we), .waddr(waddr), .wdata(dl_wd), .raddr(raddr), .rdata(dl_rd));
	ptt_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_rl (
		.clk(clk), .we(rl_we), .waddr(waddr), .wdata(c_q.item.period_ticks),
		.raddr(raddr), .rdata(rl_rd));
	ptt_ram #(.WIDTH(3), .DEPTH(DEPTH)) u_mk (
		.clk(clk), .we(mk_we), .waddr(waddr), .wdata(mk_wd), .raddr(raddr), .rdata(mk_rd));

	assign cs    = SW'(c_q.item.task_slot);
	assign ct    = TW'(c_q.item.tmr_sel);
	assign caddr = {cs, ct};
	assign saddr = scan_q[AW-1:0];
	assign ss    = scan_q[AW-1:TW];
	assign stt   = scan_q[TW-1:0];
	// Marks read as zero until first written after reset
	assign cm    = mk_vld_q[caddr] ? mk_rd : 3'b000;
	assign sm    = mk_vld_q[saddr] ? mk_rd : 3'b000;
	assign make = (st_q == ST_EXEC) && c_q.slot_ok && c_q.timer_ok &&
		(((c_q.item.action == ptt_pkg::ACT_CREATE) && !cm[0]) ||
		 ((c_q.item.action == ptt_pkg::ACT_RESTART) && cm[0]));
	// Scan entry is live: slot 1 up, in range, waiting, timer in use
	assign live = (st_q == ST_SCAN) && (ss != '0) && ({{(32-SW){1'b0}}, ss} < NUM_SLOTS)
		&& ({{(32-TW){1'b0}}, stt} < NUM_TIMERS) && wait_q[ss] && sm[0];
	assign hit = live && sm[1] && (dl_rd == tick_q);
	// Slots above 7 have no bit in ready_mask
	assign ss_in_mask = {{(32-SW){1'b0}}, ss} < 32'd8;

	always_comb begin
		// Command entry is read in ST_RD; the scan reads one entry ahead
		raddr = caddr;
		if (st_q == ST_EXEC) raddr = saddr;
		if (st_q == ST_SCAN) raddr = saddr + AW'(1);
		waddr = (st_q == ST_SCAN) ? saddr : caddr;
		dl_we = make || (live && (!sm[1] || (hit && sm[2])));
		rl_we = make;
		if (make)        dl_wd = tick_q + c_q.item.period_ticks;
		else if (!sm[1]) dl_wd = dl_rd + 32'd1;
		else             dl_wd = tick_q + rl_rd;
		// Mark updates of the single-timer actions
		mk_we = 1'b0;
		mk_wd = cm;
		if (st_q == ST_EXEC && c_q.slot_ok && c_q.timer_ok) begin
			case (c_q.item.action)
				ptt_pkg::ACT_CREATE, ptt_pkg::ACT_RESTART: begin
					mk_we = make;
					mk_wd = {c_q.item.mode_flags[0], c_q.item.mode_flags[1], 1'b1};
				end
				ptt_pkg::ACT_START: begin
					mk_we = cm[0];
					mk_wd = cm | 3'b010;
				end
				ptt_pkg::ACT_STOP: begin
					mk_we = 1'b1;
					mk_wd = cm & 3'b101;
				end
				ptt_pkg::ACT_DESTROY: begin
					mk_we = 1'b1;
					mk_wd = 3'b000;
				end
				default: begin
					mk_we = 1'b0;
					mk_wd = cm;
				end
			endcase
		end
	end

	assign cmd_ready = st_q == ST_IDLE;
	assign out_valid = st_q == ST_OUT;
	assign out_item  = res_q;

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && cmd_valid) c_q <= cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			tick_q <= '0;
			scan_q <= '0;
			ready_q <= '0;
			res_q <= '0;
			mk_vld_q <= '0;
			for (int s = 0; s < NUM_SLOTS; s++) begin
				exp_q[s] <= '0; widx_q[s] <= '0; wby_q[s] <= 1'b0; wait_q[s] <= 1'b0;
			end
		end else begin
			if (mk_we) mk_vld_q[caddr] <= 1'b1;
			case (st_q)
				ST_IDLE: if (cmd_valid) begin
					scan_q <= '0;
					st_q <= ST_RD;
				end
				ST_RD: st_q <= ST_EXEC;
				ST_EXEC: begin
					res_q <= '0;
					st_q <= ST_OUT;
					if (c_q.item.action == ptt_pkg::ACT_TICK) begin
						if (os_started) begin
							tick_q <= tick_q + 32'd1;
							ready_q <= '0;
							st_q <= ST_SCAN;
						end
					end else if (c_q.slot_ok) begin
						case (c_q.item.action)
							ptt_pkg::ACT_CREATE:
								if (!c_q.timer_ok || cm[0]) res_q.status <= 1'b1;
							ptt_pkg::ACT_RESTART, ptt_pkg::ACT_START:
								if (!c_q.timer_ok || !cm[0]) res_q.status <= 1'b1;
							ptt_pkg::ACT_READ: begin
								res_q.expired_mask <= exp_q[cs];
								res_q.last_wake_index <= 3'(widx_q[cs]);
								res_q.woke_by_timer <= wby_q[cs];
								exp_q[cs] <= '0;
							end
							ptt_pkg::ACT_WAIT: wait_q[cs] <= c_q.item.wait_on_timer;
							// stop and destroy only change marks
							default: begin
							end
						endcase
					end
				end
				// One memory entry per cycle; next address read ahead
				ST_SCAN: begin
					if (hit) begin
						if (ss_in_mask) ready_q[3'(ss)] <= 1'b1;
						exp_q[ss][3'(stt)] <= 1'b1;
						wby_q[ss] <= 1'b1;
						widx_q[ss] <= 3'(stt);
					end
					if (scan_q[AW-1:0] == AW'(DEPTH - 1)) begin
						res_q <= '0;
						res_q.ready_mask <= ready_q | ((hit && ss_in_mask) ?
							(8'd1 << 3'(ss)) : 8'd0);
						st_q <= ST_OUT;
					end
					scan_q <= scan_q + 1'b1;
				end
				ST_OUT: if (out_ready) st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule
